// File: src/strs_pkg.sv
// ----------------------------------------------------------------------------
// strs_pkg: shared types and constants of the segment tree range sum unit
// Field widths, stream packing offsets, request codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package strs_pkg;

  localparam int IDX_W   = 10;
  localparam int VAL_W   = 16;
  localparam int TOTAL_W = 26;

  // Input tdata packing, lowest bit first.
  localparam int POS_LSB   = 0;
  localparam int VAL_LSB   = POS_LSB + IDX_W;
  localparam int FIRST_LSB = VAL_LSB + VAL_W;
  localparam int LAST_LSB  = FIRST_LSB + IDX_W;
  localparam int IN_DATA_W = 48;

  localparam int OUT_DATA_W = 32;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_READ,
    ST_UPD_ADD,
    ST_Q_LO,
    ST_Q_HI,
    ST_FIN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// File: src/segment_tree_range_sum_unit.sv
// ----------------------------------------------------------------------------
// segment_tree_range_sum_unit: point-update / range-sum segment tree
// Node sums live in a single-port-write, registered-read memory walked by a
// small sequencer that shares one adder for path updates and range sums.
// ----------------------------------------------------------------------------
// The unit holds 2*NUM_LEAVES node sums in an internal memory. After reset it
// clears every node before the first beat is taken. An update (tuser 0) writes
// one leaf and then climbs to the root, a sibling read and then an add and
// parent write per tree level, and returns the new whole-array total; an
// update whose position is out of range changes nothing and returns the total.
// A query (tuser 1) walks the two range bounds upward, a Q_LO step and a Q_HI
// step per level, with at most one memory read per bound per level. The unit is
// ready again in the cycle after a result is loaded. The pace of the walks is
// set by the one memory read port and the shared adder. A new request is taken
// only when the unit is idle, but it may be taken while the previous result
// still waits on the output register.
`default_nettype none

module segment_tree_range_sum_unit #(
  parameter int NUM_LEAVES = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // position[9:0], leaf_value[25:10], range_first[35:26], range_last[45:36]
  input  wire logic [strs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // req_type[0]
  input  wire logic                               s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // total[25:0]
  output logic [strs_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);

  localparam int IW = $clog2(2 * NUM_LEAVES);
  localparam int HW = $clog2(2 * NUM_LEAVES + 1);
  localparam int NW = strs_pkg::IDX_W + 1;
  localparam int EW = strs_pkg::IDX_W + 2;
  localparam int TW = strs_pkg::TOTAL_W;
  localparam logic [HW-1:0] SLOTS   = HW'(2 * NUM_LEAVES);
  localparam logic [HW-1:0] LAST_SLOT = HW'(2 * NUM_LEAVES - 1);
  localparam logic [NW-1:0] N_NARROW = NW'(NUM_LEAVES);
  localparam logic [EW-1:0] N_WIDE   = EW'(NUM_LEAVES);

  // Input fields.
  logic [strs_pkg::IDX_W-1:0] position;
  logic [strs_pkg::VAL_W-1:0] leaf_value;
  logic [strs_pkg::IDX_W-1:0] range_first;
  logic [strs_pkg::IDX_W-1:0] range_last;

  assign position    = s_axis_tdata[strs_pkg::POS_LSB +: strs_pkg::IDX_W];
  assign leaf_value  = s_axis_tdata[strs_pkg::VAL_LSB +: strs_pkg::VAL_W];
  assign range_first = s_axis_tdata[strs_pkg::FIRST_LSB +: strs_pkg::IDX_W];
  assign range_last  = s_axis_tdata[strs_pkg::LAST_LSB +: strs_pkg::IDX_W];

  // Registers.
  strs_pkg::state_t      state, state_next;
  logic [HW-1:0]         lo, lo_next;
  logic [HW-1:0]         hi, hi_next;
  logic signed [TW-1:0]  acc, acc_next;
  logic                  rd_pend;
  logic signed [TW-1:0]  rd_data;
  logic [TW-1:0]         out_total, out_total_next;
  logic                  out_valid, out_valid_next;

  // Memory controls.
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic signed [TW-1:0]  wr_data;

  logic signed [TW-1:0]  node_sums [2 * NUM_LEAVES];

  // Request decode.
  logic                  accept;
  logic                  pos_ok;
  logic                  q_empty;
  logic [NW-1:0]         last_clip;
  logic [HW-1:0]         leaf_k;
  logic [HW-1:0]         lo_q;
  logic [HW-1:0]         hi_q;
  logic signed [TW-1:0]  leaf_ext;
  logic signed [TW-1:0]  add_sum;
  logic [HW-1:0]         lo_sib;
  logic [HW-1:0]         hi_dec;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign pos_ok   = {1'b0, position} < N_NARROW;
  assign q_empty  = (range_first > range_last) || ({1'b0, range_first} >= N_NARROW);
  assign last_clip = ({1'b0, range_last} >= N_NARROW) ? (N_NARROW - NW'(1))
                                                      : {1'b0, range_last};
  assign leaf_k   = HW'({2'b00, position} + N_WIDE);
  assign lo_q     = HW'({2'b00, range_first} + N_WIDE);
  assign hi_q     = HW'({1'b0, last_clip} + N_WIDE + EW'(1));
  assign leaf_ext = {{(TW - strs_pkg::VAL_W){leaf_value[strs_pkg::VAL_W-1]}}, leaf_value};
  assign lo_sib   = lo ^ HW'(1);
  assign hi_dec   = hi - HW'(1);

  // The one shared adder: path sums on update, range accumulation on query.
  assign add_sum  = acc + rd_data;

  assign s_axis_tready = (state == strs_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(strs_pkg::OUT_DATA_W - TW){1'b0}}, out_total};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_sums[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= node_sums[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= strs_pkg::ST_CLEAR;
      lo        <= '0;
      hi        <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      lo        <= lo_next;
      hi        <= hi_next;
      rd_pend   <= rd_en;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    acc       <= acc_next;
    out_total <= out_total_next;
  end

  always_comb begin
    state_next     = state;
    lo_next        = lo;
    hi_next        = hi;
    acc_next       = rd_pend ? add_sum : acc;
    out_total_next = out_total;
    out_valid_next = out_valid && !m_axis_tready;
    rd_en          = 1'b0;
    rd_addr        = lo[IW-1:0];
    wr_en          = 1'b0;
    wr_addr        = lo[IW-1:0];
    wr_data        = '0;

    unique case (state)
      strs_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        lo_next = lo + HW'(1);
        if (lo == LAST_SLOT) begin
          state_next = strs_pkg::ST_IDLE;
        end
      end

      strs_pkg::ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == strs_pkg::REQ_UPDATE) begin
            if (pos_ok) begin
              wr_en      = 1'b1;
              wr_addr    = leaf_k[IW-1:0];
              wr_data    = leaf_ext;
              acc_next   = leaf_ext;
              lo_next    = leaf_k;
              state_next = strs_pkg::ST_UPD_READ;
            end else begin
              // Nothing changes; just report the root.
              rd_en      = 1'b1;
              rd_addr    = IW'(1);
              acc_next   = '0;
              state_next = strs_pkg::ST_FIN;
            end
          end else begin
            acc_next = '0;
            lo_next  = lo_q;
            hi_next  = hi_q;
            if (q_empty) begin
              state_next = strs_pkg::ST_FIN;
            end else begin
              state_next = strs_pkg::ST_Q_LO;
            end
          end
        end
      end

      strs_pkg::ST_UPD_READ: begin
        if (lo == HW'(1)) begin
          state_next = strs_pkg::ST_FIN;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = lo_sib[IW-1:0];
          state_next = strs_pkg::ST_UPD_ADD;
        end
      end

      strs_pkg::ST_UPD_ADD: begin
        // acc holds the value of node lo; the sibling just arrived.
        wr_en      = 1'b1;
        wr_addr    = IW'(lo >> 1);
        wr_data    = add_sum;
        lo_next    = lo >> 1;
        state_next = strs_pkg::ST_UPD_READ;
      end

      strs_pkg::ST_Q_LO: begin
        if (lo >= hi) begin
          state_next = strs_pkg::ST_FIN;
        end else begin
          if (lo[0]) begin
            rd_en   = 1'b1;
            rd_addr = lo[IW-1:0];
            lo_next = lo + HW'(1);
          end
          state_next = strs_pkg::ST_Q_HI;
        end
      end

      strs_pkg::ST_Q_HI: begin
        lo_next = lo >> 1;
        if (hi[0]) begin
          rd_en   = 1'b1;
          rd_addr = hi_dec[IW-1:0];
          hi_next = hi_dec >> 1;
        end else begin
          hi_next = hi >> 1;
        end
        state_next = strs_pkg::ST_Q_LO;
      end

      strs_pkg::ST_FIN: begin
        // Any read still pending, as the root read of an out-of-range update, is folded into acc on this cycle.
        state_next = strs_pkg::ST_DONE;
      end

      strs_pkg::ST_DONE: begin
        if (!out_valid || m_axis_tready) begin
          out_total_next = acc;
          out_valid_next = 1'b1;
          state_next     = strs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = strs_pkg::ST_IDLE;
      end
    endcase
  end

  // A read result is only ever folded in the cycle after a read-issuing state.
  a_pend_source: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> ($past(state) == strs_pkg::ST_IDLE || $past(state) == strs_pkg::ST_UPD_READ
              || $past(state) == strs_pkg::ST_Q_LO || $past(state) == strs_pkg::ST_Q_HI))
    else $error("read data folded without a read");

  // The update walk always addresses a real non-root node.
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    state == strs_pkg::ST_UPD_ADD |-> (lo > HW'(1) && lo < SLOTS))
    else $error("update walk left the tree");

  // The upper query bound never passes one beyond the last slot.
  a_hi_range: assert property (@(posedge clk) disable iff (rst)
    state == strs_pkg::ST_Q_LO |-> hi <= SLOTS)
    else $error("query bound out of range");

  // An accepted beat always starts work.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != strs_pkg::ST_IDLE)
    else $error("accepted beat did not start work");

  // A result appears only out of the delivery state.
  a_out_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == strs_pkg::ST_DONE)
    else $error("result raised outside delivery");

endmodule

`default_nettype wire
